// ===== hdl/tsts_pkg.sv =====
// shared types and constants of the time-slice task scheduler
package tsts_pkg;

    // fixed field widths
    localparam int TASK_ID_W   = 9;
    localparam int BUDGET_IN_W = 16;
    localparam int TOTAL_W     = 64;

    // ready bitmap is scanned one chunk per cycle
    localparam int CHUNK_W     = 32;
    localparam int CHUNK_BIT_W = 5;

    // request type codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_FORCE = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // task state codes
    localparam logic [2:0] TS_NULL     = 3'd0;
    localparam logic [2:0] TS_CREATION = 3'd1;
    localparam logic [2:0] TS_READY    = 3'd2;
    localparam logic [2:0] TS_WAITING  = 3'd3;
    localparam logic [2:0] TS_KILL     = 3'd4;
    localparam logic [2:0] TS_RUNNING  = 3'd5;

    // controller states
    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC,
        FSM_SEARCH
    } t_fsm;

    // input transaction
    typedef struct packed {
        logic [1:0]             req_type;
        logic [TASK_ID_W-1:0]   task_id;
        logic                   new_exists;
        logic [2:0]             new_state;
        logic [BUDGET_IN_W-1:0] new_budget;
    } t_req;

    // result transaction
    typedef struct packed {
        logic [TASK_ID_W-1:0] current_task;
        logic                 switched;
        logic                 released;
        logic [TASK_ID_W-1:0] released_task;
        logic [TOTAL_W-1:0]   tick_total;
    } t_res;

    // search status from the ready bitmap
    typedef struct packed {
        logic done;
        logic found;
    } t_srch;

endpackage

// ===== hdl/tsts_table.sv =====
// task entry memory: one write port, one registered read port
module tsts_table #(
    parameter int TASK_COUNT = 512,
    parameter int TICK_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [$clog2(TASK_COUNT)-1:0]       i_wr_addr,
    input  logic [4+2*TICK_WIDTH-1:0]           i_wr_data,
    input  logic                                i_rd_en,
    input  logic [$clog2(TASK_COUNT)-1:0]       i_rd_addr,
    output logic [4+2*TICK_WIDTH-1:0]           o_rd_data
);

    localparam int ENT_W = 4 + 2 * TICK_WIDTH;

    logic [ENT_W-1:0] r_mem [TASK_COUNT];
    logic [ENT_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/tsts_ready_map.sv =====
// ready bitmap with a chunked find-next search
module tsts_ready_map #(
    parameter int TASK_COUNT = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [$clog2(TASK_COUNT)-1:0]          i_wr_idx,
    input  logic                                   i_wr_bit,
    input  logic                                   i_go,
    input  logic [((TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W > 1 ?
                   $clog2((TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W) : 1)
                  + tsts_pkg::CHUNK_BIT_W - 1:0]   i_start_idx,
    output tsts_pkg::t_srch                        o_status,
    output logic [((TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W > 1 ?
                   $clog2((TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W) : 1)
                  + tsts_pkg::CHUNK_BIT_W - 1:0]   o_idx
);

    localparam int NCH   = (TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W;
    localparam int CI_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W = CI_W + tsts_pkg::CHUNK_BIT_W;
    localparam int MAP_W = NCH * tsts_pkg::CHUNK_W;
    localparam logic [CI_W-1:0] LAST_CHUNK = CI_W'(NCH - 1);

    logic [MAP_W-1:0]              r_map;
    logic                          r_busy;
    logic [CI_W-1:0]               r_chunk;
    logic [tsts_pkg::CHUNK_W-1:0]  r_mask;

    logic [tsts_pkg::CHUNK_W-1:0]     word;
    logic [tsts_pkg::CHUNK_BIT_W-1:0] hit_bit;
    logic                             hit;
    logic                             last;

    // current chunk, masked below the start position
    assign word = r_map[{r_chunk, {tsts_pkg::CHUNK_BIT_W{1'b0}}} +: tsts_pkg::CHUNK_W] & r_mask;
    assign hit  = |word;
    assign last = (r_chunk == LAST_CHUNK);

    // lowest set bit of the chunk
    always_comb begin
        hit_bit = '0;
        for (int i = tsts_pkg::CHUNK_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                hit_bit = tsts_pkg::CHUNK_BIT_W'(i);
            end
        end
    end

    assign o_status.done  = r_busy && (hit || last);
    assign o_status.found = r_busy && hit;
    assign o_idx          = {r_chunk, hit_bit};

    // bitmap bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_wr_en) begin
            r_map[IDX_W'(i_wr_idx)] <= i_wr_bit;
        end
    end

    // search walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chunk <= '0;
            r_mask  <= '0;
        end else if (i_go) begin
            r_busy  <= 1'b1;
            r_chunk <= i_start_idx[IDX_W-1:tsts_pkg::CHUNK_BIT_W];
            r_mask  <= {tsts_pkg::CHUNK_W{1'b1}} << i_start_idx[tsts_pkg::CHUNK_BIT_W-1:0];
        end else if (r_busy) begin
            if (hit || last) begin
                r_busy <= 1'b0;
            end else begin
                r_chunk <= r_chunk + CI_W'(1);
                r_mask  <= '1;
            end
        end
    end

    // a search never reports a hit without also reporting done
    a_found_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.found |-> o_status.done)
        else $error("search hit without done");

    a_go_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_busy)
        else $error("search restarted while busy");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_wr_en)
        else $error("bitmap written during a search");

endmodule

// ===== hdl/time_slice_task_scheduler.sv =====
// top level of the round-robin time-slice task scheduler
// After reset the block clears its task table, one entry per cycle, with o_busy high. A
// transaction is taken when i_start is high and o_busy is low, and each one yields
// exactly one result, shown on o_res for a single cycle with o_done high; the receiver
// cannot hold it off. Write and unused request types give their result in the cycle
// after they are taken. A tick or forced switch reads the running task's entry and writes
// it back, except a tick on a task in creation; on a switch it scans the ready bitmap 32
// tasks per cycle from the task above the current one to the last, else picks task 0.
module time_slice_task_scheduler #(
    parameter int TASK_COUNT = 512,
    parameter int TICK_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tsts_pkg::t_req   i_req,
    output logic             o_busy,
    output logic             o_done,
    output tsts_pkg::t_res   o_res
);

    localparam int ID_W  = $clog2(TASK_COUNT);
    localparam int TW    = TICK_WIDTH;
    localparam int ENT_W = 4 + 2 * TW;
    localparam int NCH   = (TASK_COUNT + tsts_pkg::CHUNK_W - 1) / tsts_pkg::CHUNK_W;
    localparam int CI_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W = CI_W + tsts_pkg::CHUNK_BIT_W;
    localparam int CMP_W = tsts_pkg::TASK_ID_W + 4;
    localparam logic [ID_W-1:0] LAST_ID = ID_W'(TASK_COUNT - 1);

    // controller registers
    tsts_pkg::t_fsm              r_state, n_state;
    logic [ID_W-1:0]             r_clr_idx, n_clr_idx;
    tsts_pkg::t_req              r_req, n_req;
    logic [ID_W-1:0]             r_run, n_run;
    logic [tsts_pkg::TOTAL_W-1:0] r_ticks, n_ticks;
    logic                        r_rel, n_rel;
    logic                        r_done, n_done;
    tsts_pkg::t_res              r_out, n_out;

    // memory and bitmap ports
    logic                        mem_we;
    logic [ID_W-1:0]             mem_wa;
    logic [ENT_W-1:0]            mem_wd;
    logic                        mem_re;
    logic [ENT_W-1:0]            mem_rd;
    logic                        map_we;
    logic [ID_W-1:0]             map_wa;
    logic                        map_wbit;
    logic                        srch_go;
    logic [IDX_W-1:0]            srch_start;
    tsts_pkg::t_srch             srch;
    logic [IDX_W-1:0]            srch_idx;

    // fields of the entry read back
    logic                        e_exists;
    logic [2:0]                  e_state;
    logic [TW-1:0]               e_used;
    logic [TW-1:0]               e_budget;
    logic                        is_tick;
    logic                        kill;
    logic                        id_ok;

    assign e_exists = mem_rd[ENT_W-1];
    assign e_state  = mem_rd[ENT_W-2 -: 3];
    assign e_used   = mem_rd[2*TW-1:TW];
    assign e_budget = mem_rd[TW-1:0];
    assign is_tick  = (r_req.req_type == tsts_pkg::REQ_TICK);
    assign kill     = (e_state == tsts_pkg::TS_KILL);
    assign id_ok    = ({4'b0, i_req.task_id} < CMP_W'(TASK_COUNT));

    tsts_table #(
        .TASK_COUNT (TASK_COUNT),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (mem_we),
        .i_wr_addr  (mem_wa),
        .i_wr_data  (mem_wd),
        .i_rd_en    (mem_re),
        .i_rd_addr  (r_run),
        .o_rd_data  (mem_rd)
    );

    tsts_ready_map #(
        .TASK_COUNT (TASK_COUNT)
    ) u_ready_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (map_we),
        .i_wr_idx    (map_wa),
        .i_wr_bit    (map_wbit),
        .i_go        (srch_go),
        .i_start_idx (srch_start),
        .o_status    (srch),
        .o_idx       (srch_idx)
    );

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsts_pkg::FSM_CLEAR;
            r_clr_idx <= '0;
            r_run     <= '0;
            r_ticks   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_run     <= n_run;
            r_ticks   <= n_ticks;
            r_done    <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rel <= n_rel;
        r_out <= n_out;
    end

    // next state, table access and result
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_req      = r_req;
        n_run      = r_run;
        n_ticks    = r_ticks;
        n_rel      = r_rel;
        n_done     = 1'b0;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_wa     = r_run;
        mem_wd     = '0;
        mem_re     = 1'b0;
        map_we     = 1'b0;
        map_wa     = ID_W'(i_req.task_id);
        map_wbit   = i_req.new_exists && (i_req.new_state == tsts_pkg::TS_READY);
        srch_go    = 1'b0;
        srch_start = IDX_W'(r_run) + IDX_W'(1);

        case (r_state)
            // clearing pass over the table after reset
            tsts_pkg::FSM_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_idx;
                if (r_clr_idx == LAST_ID) begin
                    n_state = tsts_pkg::FSM_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + ID_W'(1);
                end
            end

            // take a transaction
            tsts_pkg::FSM_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_rel = 1'b0;
                    case (i_req.req_type)
                        tsts_pkg::REQ_TICK: begin
                            n_ticks = r_ticks + tsts_pkg::TOTAL_W'(1);
                            mem_re  = 1'b1;
                            n_state = tsts_pkg::FSM_EXEC;
                        end
                        tsts_pkg::REQ_FORCE: begin
                            mem_re  = 1'b1;
                            n_state = tsts_pkg::FSM_EXEC;
                        end
                        tsts_pkg::REQ_WRITE: begin
                            if (id_ok) begin
                                mem_we = 1'b1;
                                mem_wa = ID_W'(i_req.task_id);
                                mem_wd = {i_req.new_exists, i_req.new_state, TW'(0),
                                          TW'(i_req.new_budget)};
                                map_we = 1'b1;
                            end
                            n_done              = 1'b1;
                            n_out.current_task  = tsts_pkg::TASK_ID_W'(r_run);
                            n_out.switched      = 1'b0;
                            n_out.released      = 1'b0;
                            n_out.released_task = '0;
                            n_out.tick_total    = r_ticks;
                        end
                        default: begin
                            n_done              = 1'b1;
                            n_out.current_task  = tsts_pkg::TASK_ID_W'(r_run);
                            n_out.switched      = 1'b0;
                            n_out.released      = 1'b0;
                            n_out.released_task = '0;
                            n_out.tick_total    = r_ticks;
                        end
                    endcase
                end
            end

            // entry of the running task is here: check the slice and write back
            tsts_pkg::FSM_EXEC: begin
                n_out.current_task  = tsts_pkg::TASK_ID_W'(r_run);
                n_out.switched      = 1'b0;
                n_out.released      = 1'b0;
                n_out.released_task = '0;
                n_out.tick_total    = r_ticks;
                if (is_tick && e_state == tsts_pkg::TS_CREATION) begin
                    n_done  = 1'b1;
                    n_state = tsts_pkg::FSM_IDLE;
                end else if (!is_tick || e_used >= e_budget || kill ||
                             e_state == tsts_pkg::TS_WAITING) begin
                    mem_we = 1'b1;
                    mem_wd = {e_exists && !kill,
                              kill ? tsts_pkg::TS_NULL : e_state,
                              TW'(0),
                              (kill && !is_tick) ? TW'(0) : e_budget};
                    n_rel  = kill;
                    if (r_run == LAST_ID) begin
                        n_run               = '0;
                        n_done              = 1'b1;
                        n_out.current_task  = '0;
                        n_out.switched      = 1'b1;
                        n_out.released      = kill;
                        n_out.released_task = kill ? tsts_pkg::TASK_ID_W'(r_run) : '0;
                        n_state             = tsts_pkg::FSM_IDLE;
                    end else begin
                        srch_go = 1'b1;
                        n_state = tsts_pkg::FSM_SEARCH;
                    end
                end else begin
                    mem_we  = 1'b1;
                    mem_wd  = {e_exists, e_state, e_used + TW'(1), e_budget};
                    n_done  = 1'b1;
                    n_state = tsts_pkg::FSM_IDLE;
                end
            end

            // walk the ready bitmap for the next task
            tsts_pkg::FSM_SEARCH: begin
                if (srch.done) begin
                    n_run               = srch.found ? ID_W'(srch_idx) : '0;
                    n_done              = 1'b1;
                    n_out.current_task  = tsts_pkg::TASK_ID_W'(n_run);
                    n_out.switched      = 1'b1;
                    n_out.released      = r_rel;
                    n_out.released_task = r_rel ? tsts_pkg::TASK_ID_W'(r_run) : '0;
                    n_out.tick_total    = r_ticks;
                    n_state             = tsts_pkg::FSM_IDLE;
                end
            end

            default: begin
                n_state = tsts_pkg::FSM_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tsts_pkg::FSM_IDLE);
    assign o_done = r_done;
    assign o_res  = r_out;

    // no result while the table is being cleared
    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsts_pkg::FSM_CLEAR) |-> !o_done)
        else $error("result during clearing pass");

    a_release_needs_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.released) |-> o_res.switched)
        else $error("release without task switch");

    a_release_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.released) |-> (o_res.released_task == '0))
        else $error("released task set without release");

    a_single_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("table read and write in the same cycle");

    a_search_above_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsts_pkg::FSM_SEARCH && srch.found) |-> (srch_idx > IDX_W'(r_run)))
        else $error("search found a task at or below the running one");

endmodule
